### design/utf8_to_utf16_decoder_top_macros.svh
// Assertion macros for the UTF-8 to 16-bit unit decoder.
// Each macro expands to one labeled concurrent assertion on clock, gated by reset.
`ifndef UTF8_TO_UTF16_DECODER_TOP_MACROS_SVH
`define UTF8_TO_UTF16_DECODER_TOP_MACROS_SVH

// Check prop in the same cycle as cond.
`define U8U16_ASSERT_NOW(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// Check prop in the cycle after cond.
`define U8U16_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

### design/u8u16_pkg.sv
// Shared widths, constants and byte decode helpers for the UTF-8 decoder.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package u8u16_pkg;

   localparam int BYTE_W  = 8;
   localparam int UNIT_W  = 16;
   localparam int PEND_W  = 3;
   localparam int VALUE_W = 31;

   localparam logic [PEND_W-1:0] MAX_PENDING = 3'd5;
   localparam logic [1:0]        CONT_TAG    = 2'b10;
   localparam logic [UNIT_W-1:0] SUBST_UNIT  = 16'h003F;

   // Leading-one counts with a meaning of their own
   localparam logic [PEND_W-1:0] LEAD_ASCII = 3'd0;
   localparam logic [PEND_W-1:0] LEAD_CONT  = 3'd1;
   localparam logic [PEND_W-1:0] LEAD_BAD   = 3'd7;

   // Count leading ones of a byte, saturating at seven
   function automatic logic [PEND_W-1:0] lead_ones(input logic [BYTE_W-1:0] b);
      logic [PEND_W-1:0] n;
      n = LEAD_BAD;
      unique casez (b)
         8'b0???????: n = LEAD_ASCII;
         8'b10??????: n = LEAD_CONT;
         8'b110?????: n = 3'd2;
         8'b1110????: n = 3'd3;
         8'b11110???: n = 3'd4;
         8'b111110??: n = 3'd5;
         8'b1111110?: n = 3'd6;
         default:     n = LEAD_BAD;
      endcase
      return n;
   endfunction

   // Payload bits of a lead byte, placed above the continuation bytes to come
   function automatic logic [VALUE_W-1:0] lead_bits(input logic [BYTE_W-1:0] b,
                                                    input logic [PEND_W-1:0] lead);
      logic [VALUE_W-1:0] v;
      v = '0;
      unique case (lead)
         3'd2:    v = {20'b0, b[4:0], 6'b0};
         3'd3:    v = {15'b0, b[3:0], 12'b0};
         3'd4:    v = {10'b0, b[2:0], 18'b0};
         3'd5:    v = {5'b0, b[1:0], 24'b0};
         3'd6:    v = {b[0], 30'b0};
         default: v = '0;
      endcase
      return v;
   endfunction

   // Six payload bits of a continuation byte, placed by the count still left
   function automatic logic [VALUE_W-1:0] cont_bits(input logic [5:0] p,
                                                    input logic [PEND_W-1:0] left);
      logic [VALUE_W-1:0] v;
      v = '0;
      unique case (left)
         3'd0:    v = {25'b0, p};
         3'd1:    v = {19'b0, p, 6'b0};
         3'd2:    v = {13'b0, p, 12'b0};
         3'd3:    v = {7'b0, p, 18'b0};
         3'd4:    v = {1'b0, p, 24'b0};
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

### design/u8u16_req_if.sv
// Byte input channel of the UTF-8 decoder: valid/ready plus one raw byte.
// Depends on u8u16_pkg for field widths.
`timescale 1ns / 1ps

interface u8u16_req_if import u8u16_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;
   logic              new_string;

   modport source (output valid, output in_byte, output new_string, input ready);
   modport sink   (input valid, input in_byte, input new_string, output ready);
endinterface

### design/u8u16_rsp_if.sv
// Result channel of the UTF-8 decoder: valid/ready plus one 16-bit unit.
// Depends on u8u16_pkg for field widths.
`timescale 1ns / 1ps

interface u8u16_rsp_if import u8u16_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [UNIT_W-1:0] code_unit;
   logic              ended;

   modport source (output valid, output code_unit, output ended, input ready);
   modport sink   (input valid, input code_unit, input ended, output ready);
endinterface

### design/utf8_to_utf16_decoder_top.v.sv
// UTF-8 (up to six-byte forms) to 16-bit unit decoder; uses u8u16_pkg and both channel ifs.
// Datapath: an accepted byte is held in the input register and its unit is written to the
// result register (input reg, result reg).
// Throughput: one byte per cycle barring the stall below; decode updates sequence state per byte.
// A byte with no result moves on even while a result waits; one that yields a unit waits
// for the result register. Synchronous reset clears valids, sequence state and stop flag.
`timescale 1ns / 1ps
`include "utf8_to_utf16_decoder_top_macros.svh"

module utf8_to_utf16_decoder_top import u8u16_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   u8u16_req_if.sink   req_chan,
   u8u16_rsp_if.source rsp_chan
);

   // Input register
   logic              s1_valid_ff;
   logic [BYTE_W-1:0] s1_byte_ff;
   logic              s1_new_ff;

   // Decoder state: low 16 bits of the value plus a sticky flag for anything above
   logic [PEND_W-1:0] pend_ff, pend_in;
   logic [UNIT_W-1:0] part_ff, part_in;
   logic              over_ff, over_in;
   logic              stop_ff, stop_in;

   // Result register
   logic              rsp_valid_ff;
   logic [UNIT_W-1:0] rsp_code_ff;
   logic              rsp_ended_ff;

   logic              out_free;
   logic              emit;
   logic              process;
   logic [UNIT_W-1:0] unit_out;
   logic              ended_out;

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign process        = s1_valid_ff && (out_free || !emit);
   assign req_chan.ready = !s1_valid_ff || process;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
      if (req_chan.ready && req_chan.valid) begin
         s1_byte_ff <= req_chan.in_byte;
         s1_new_ff  <= req_chan.new_string;
      end
   end

   // Decode one byte against the sequence state
   always_comb begin
      logic [PEND_W-1:0]  pend_v;
      logic [UNIT_W-1:0]  part_v;
      logic               over_v;
      logic               stop_v;
      logic [PEND_W-1:0]  lead;
      logic [PEND_W-1:0]  left;
      logic [VALUE_W-1:0] bits;
      logic               done;
      logic [UNIT_W-1:0]  done_low;
      logic               done_over;

      // String start clears the stop and drops any unfinished character
      pend_v = s1_new_ff ? '0 : pend_ff;
      part_v = s1_new_ff ? '0 : part_ff;
      over_v = s1_new_ff ? 1'b0 : over_ff;
      stop_v = s1_new_ff ? 1'b0 : stop_ff;

      lead      = lead_ones(s1_byte_ff);
      left      = pend_v - 3'd1;
      bits      = '0;
      done      = 1'b0;
      done_low  = '0;
      done_over = 1'b0;

      pend_in   = pend_v;
      part_in   = part_v;
      over_in   = over_v;
      stop_in   = stop_v;
      emit      = 1'b0;
      unit_out  = '0;
      ended_out = 1'b0;

      if (!stop_v) begin
         if (pend_v != '0) begin
            if (s1_byte_ff[7:6] != CONT_TAG) begin
               stop_in = 1'b1;
               pend_in = '0;
               part_in = '0;
               over_in = 1'b0;
            end else begin
               bits    = cont_bits(s1_byte_ff[5:0], left);
               pend_in = left;
               part_in = part_v | bits[UNIT_W-1:0];
               over_in = over_v | (|bits[VALUE_W-1:UNIT_W]);
               if (left == '0) begin
                  done      = 1'b1;
                  done_low  = part_in;
                  done_over = over_in;
               end
            end
         end else begin
            unique case (lead)
               LEAD_ASCII: begin
                  done     = 1'b1;
                  done_low = {{(UNIT_W-BYTE_W){1'b0}}, s1_byte_ff};
               end
               LEAD_CONT, LEAD_BAD: begin
                  // skip stray continuation, 0xFE and 0xFF
               end
               default: begin
                  bits    = lead_bits(s1_byte_ff, lead);
                  pend_in = lead - 3'd1;
                  part_in = bits[UNIT_W-1:0];
                  over_in = |bits[VALUE_W-1:UNIT_W];
               end
            endcase
         end
      end

      if (done) begin
         unit_out  = done_over ? SUBST_UNIT : done_low;
         ended_out = (unit_out == '0);
         emit      = 1'b1;
         pend_in   = '0;
         part_in   = '0;
         over_in   = 1'b0;
         if (ended_out) begin
            stop_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         part_ff <= '0;
         over_ff <= 1'b0;
         stop_ff <= 1'b0;
      end else if (process) begin
         pend_ff <= pend_in;
         part_ff <= part_in;
         over_ff <= over_in;
         stop_ff <= stop_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= process && emit;
      end
      if (process && emit) begin
         rsp_code_ff  <= unit_out;
         rsp_ended_ff <= ended_out;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.code_unit = rsp_code_ff;
   assign rsp_chan.ended     = rsp_ended_ff;

   `U8U16_ASSERT_NOW(a_pend_range, 1'b1, pend_ff <= MAX_PENDING, "pending count above five")
   `U8U16_ASSERT_NOW(a_stop_clean, stop_ff,
      pend_ff == '0 && part_ff == '0 && !over_ff, "state not cleared while stopped")
   `U8U16_ASSERT_NOW(a_over_pending, over_ff, pend_ff != '0,
      "high-value flag left without a pending sequence")
   `U8U16_ASSERT_NOW(a_ended_nul, rsp_valid_ff, rsp_ended_ff == (rsp_code_ff == '0),
      "end flag disagrees with unit")
   `U8U16_ASSERT_NEXT(a_nul_stops, process && emit && ended_out, stop_ff,
      "decoded NUL did not stop decoding")

endmodule

### bench/tb.sv
// Testbench for utf8_to_utf16_decoder_top: directed and random byte strings checked against
// an in-bench decoder model. Depends on u8u16_pkg and the req/rsp channel interfaces.
`timescale 1ns / 1ps

module tb;
   import u8u16_pkg::*;

   typedef struct packed {
      logic [UNIT_W-1:0] code_unit;
      logic              ended;
   } unit_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   u8u16_req_if req_if ();
   u8u16_rsp_if rsp_if ();

   utf8_to_utf16_decoder_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // Decoder model state
   logic [PEND_W-1:0]  dec_pending = '0;
   logic [VALUE_W-1:0] dec_value   = '0;
   logic               dec_stopped = 1'b0;

   unit_item_type pending_units[$];

   int err_count      = 0;
   int bytes_accepted = 0;
   int units_checked  = 0;
   int items_sent     = 0;

   // Idle controls for the sender and the receiver
   bit send_idle     = 1'b0;
   bit recv_idle     = 1'b0;
   int long_hold_req = 0;
   int hold_left     = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("tb: failure");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      err_count++;
   endtask

   // Close a finished character: substitute wide values, flag a NUL
   function automatic unit_item_type close_char(input logic [VALUE_W-1:0] v);
      unit_item_type u;
      u.code_unit = (v[VALUE_W-1:UNIT_W] != '0) ? SUBST_UNIT : v[UNIT_W-1:0];
      u.ended     = (u.code_unit == '0);
      if (u.ended) dec_stopped = 1'b1;
      dec_pending = '0;
      dec_value   = '0;
      return u;
   endfunction

   function automatic void decode_byte(input logic [BYTE_W-1:0] b, input logic ns,
                                       output bit got, output unit_item_type u);
      int n;
      got = 1'b0;
      u   = '0;
      n   = 0;
      if (ns) begin
         dec_stopped = 1'b0;
         dec_pending = '0;
         dec_value   = '0;
      end
      if (dec_stopped) return;
      if (dec_pending != '0) begin
         if (b[7:6] != 2'b10) begin
            dec_stopped = 1'b1;
            dec_pending = '0;
            dec_value   = '0;
            return;
         end
         dec_pending = dec_pending - PEND_W'(1);
         dec_value   = dec_value | (VALUE_W'(b[5:0]) << (int'(dec_pending) * 6));
         if (dec_pending == '0) begin
            u   = close_char(dec_value);
            got = 1'b1;
         end
         return;
      end
      while (n < 7 && b[7-n]) n++;
      // skip stray continuation, 0xFE and 0xFF
      if (n == 1 || n > 6) return;
      if (n == 0) begin
         u   = close_char(VALUE_W'(b));
         got = 1'b1;
         return;
      end
      dec_pending = PEND_W'(n - 1);
      dec_value   = VALUE_W'(b & (8'hFF >> (n + 1))) << ((n - 1) * 6);
   endfunction

   always @(posedge clock) begin : monitor
      bit            got;
      unit_item_type u;
      unit_item_type want;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            decode_byte(req_if.in_byte, req_if.new_string, got, u);
            bytes_accepted++;
            if (got) pending_units.push_back(u);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            units_checked++;
            if (pending_units.size() == 0) begin
               report_mismatch($sformatf("unexpected unit %h ended %b",
                                         rsp_if.code_unit, rsp_if.ended));
            end else begin
               want = pending_units.pop_front();
               if (rsp_if.code_unit !== want.code_unit)
                  report_mismatch($sformatf("code_unit %h, predicted %h",
                                            rsp_if.code_unit, want.code_unit));
               if (rsp_if.ended !== want.ended)
                  report_mismatch($sformatf("ended %b, predicted %b for unit %h",
                                            rsp_if.ended, want.ended, want.code_unit));
            end
         end
      end
   end

   // Idle length: mostly short, now and then long
   function automatic int pick_idle();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return $urandom_range(1, 2);
      if (r < 95) return $urandom_range(3, 8);
      return $urandom_range(20, 50);
   endfunction

   always @(negedge clock) begin
      if (long_hold_req > 0) begin
         rsp_if.ready  <= 1'b0;
         hold_left      = long_hold_req - 1;
         long_hold_req  = 0;
      end else if (hold_left > 0) begin
         rsp_if.ready <= 1'b0;
         hold_left--;
      end else if (!recv_idle || $urandom_range(0, 99) < 70) begin
         rsp_if.ready <= 1'b1;
      end else begin
         rsp_if.ready <= 1'b0;
         hold_left     = pick_idle() - 1;
      end
   end

   // Call at a falling edge; returns at a falling edge after the item is taken
   task automatic send_byte(input logic ns, input logic [BYTE_W-1:0] b);
      int gap;
      req_if.valid      <= 1'b1;
      req_if.in_byte    <= b;
      req_if.new_string <= ns;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      items_sent++;
      @(negedge clock);
      gap = 0;
      if (send_idle && $urandom_range(0, 99) >= 65) gap = pick_idle();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Lead byte of a len-byte form followed by conts continuation bytes
   task automatic send_char(input int len, input logic ns, input int conts);
      logic [BYTE_W-1:0] b;
      if (len == 1) begin
         send_byte(ns, BYTE_W'($urandom_range(1, 127)));
      end else begin
         b = (8'hFF << (8 - len)) | (BYTE_W'($urandom) & (8'hFF >> (len + 1)));
         send_byte(ns, b);
         repeat (conts) send_byte(1'b0, 8'h80 | BYTE_W'($urandom_range(0, 63)));
      end
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (pending_units.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic test_forms();
      send_byte(1'b1, 8'h41);
      send_byte(1'b0, 8'h7F);
      send_byte(1'b0, 8'hC3);
      send_byte(1'b0, 8'hA9);
      send_byte(1'b0, 8'hE2);
      send_byte(1'b0, 8'h82);
      send_byte(1'b0, 8'hAC);
      // four-byte form lands above 0xFFFF
      send_byte(1'b0, 8'hF0);
      send_byte(1'b0, 8'h9F);
      send_byte(1'b0, 8'h98);
      send_byte(1'b0, 8'h80);
      // widest six-byte value
      send_byte(1'b0, 8'hFD);
      repeat (5) send_byte(1'b0, 8'hBF);
      wait_drained();
   endtask

   task automatic test_specials();
      // stray continuation and the two never-valid bytes
      send_byte(1'b0, 8'h80);
      send_byte(1'b0, 8'hFE);
      send_byte(1'b0, 8'hFF);
      // broken sequence halts; next byte ignored
      send_byte(1'b0, 8'hE2);
      send_byte(1'b0, 8'h41);
      send_byte(1'b0, 8'h42);
      // restart mid-character drops it
      send_byte(1'b1, 8'hC3);
      send_byte(1'b1, 8'h41);
      // overlong NUL ends the string
      send_byte(1'b0, 8'hC0);
      send_byte(1'b0, 8'h80);
      send_byte(1'b0, 8'h43);
      send_byte(1'b1, 8'h00);
      wait_drained();
   endtask

   task automatic test_backpressure();
      send_idle     = 1'b0;
      long_hold_req = 200;
      @(negedge clock);
      repeat (40) send_byte(1'b0, BYTE_W'($urandom_range(1, 127)));
      send_byte(1'b1, 8'h44);
      wait_drained();
   endtask

   task automatic test_random_strings(input int n_items);
      int  target;
      int  chars;
      int  kind;
      int  len;
      int  next_toggle;
      bit  first;
      bit  done;
      logic [BYTE_W-1:0] b;
      target      = items_sent + n_items;
      next_toggle = items_sent;
      while (items_sent < target) begin
         if (items_sent >= next_toggle) begin
            send_idle   = ($urandom_range(0, 3) != 0);
            recv_idle   = ($urandom_range(0, 3) != 0);
            next_toggle = items_sent + $urandom_range(100, 250);
         end
         chars = $urandom_range(1, 10);
         first = 1'b1;
         done  = 1'b0;
         for (int c = 0; c < chars && !done; c++) begin
            kind = $urandom_range(0, 99);
            len  = $urandom_range(0, 99);
            len  = (len < 30) ? 1 : (len < 55) ? 2 : (len < 80) ? 3 :
                   (len < 90) ? 4 : (len < 95) ? 5 : 6;
            if (kind < 78) begin
               send_char(len, first, len - 1);
            end else if (kind < 86) begin
               b = ($urandom_range(0, 2) == 0) ? 8'hFE + BYTE_W'($urandom_range(0, 1))
                                                : 8'h80 | BYTE_W'($urandom_range(0, 63));
               send_byte(first, b);
            end else if (kind < 90) begin
               // truncated, then a byte that is no continuation
               len = $urandom_range(2, 6);
               send_char(len, first, $urandom_range(0, len - 2));
               do b = BYTE_W'($urandom); while (b[7:6] == 2'b10);
               send_byte(1'b0, b);
               done = 1'b1;
            end else if (kind < 93) begin
               case ($urandom_range(0, 2))
                  0: send_byte(first, 8'h00);
                  1: begin
                     send_byte(first, 8'hC0);
                     send_byte(1'b0, 8'h80);
                  end
                  default: begin
                     send_byte(first, 8'hE0);
                     send_byte(1'b0, 8'h80);
                     send_byte(1'b0, 8'h80);
                  end
               endcase
               done = 1'b1;
            end else if (kind < 96) begin
               // unfinished char, dropped by the next string start
               len = $urandom_range(2, 6);
               send_char(len, first, $urandom_range(0, len - 2));
               done = 1'b1;
            end else begin
               send_byte($urandom_range(0, 7) == 0, BYTE_W'($urandom));
            end
            first = 1'b0;
         end
         if ($urandom_range(0, 49) == 0) wait_drained();
      end
      wait_drained();
   endtask

   initial begin
      req_if.valid      = 1'b0;
      req_if.in_byte    = '0;
      req_if.new_string = 1'b0;
      rsp_if.ready      = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      test_forms();
      test_specials();
      test_backpressure();
      test_random_strings(2000);
      recv_idle = 1'b1;
      send_idle = 1'b1;
      test_backpressure();

      $display("tb: %0d bytes accepted, %0d units checked, %0d mismatches",
               bytes_accepted, units_checked, err_count);
      $display("tb: covered one- to six-byte forms, skips, halts and restarts under stalls");
      if (err_count == 0 && pending_units.size() == 0) begin
         $display("tb: success");
      end else begin
         if (pending_units.size() != 0)
            report_mismatch($sformatf("%0d units never arrived", pending_units.size()));
         $display("tb: failure");
      end
      $finish;
   end

endmodule
